[rtl/wmsa_pkg.sv]
// shared constants for the weighted mode-sum accumulator
`default_nettype none

package wmsa_pkg;

    // default store and mode limits
    localparam int MAX_PIXELS_DEF = 65536;
    localparam int MAX_MODES_DEF  = 1024;

    // payload widths
    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 48;
    localparam int IDX_W  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int PIX_REQ_W  = 17;
    localparam int MODE_REQ_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_PIXELS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODES_IN_USE  = 1'b1;

    // register values after reset, before clamping
    localparam int PIX_RESET  = 65536;
    localparam int MODE_RESET = 1024;

endpackage

`default_nettype wire

[rtl/weighted_mode_sum_accumulator_top.sv]
// top level of the weighted mode-sum accumulator
`default_nettype none

// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------------------
// s_        | in        | s_valid / s_ready      | s_mode_pixel, s_weight (signed q1.15)
// m_        | out       | m_valid / m_ready      | m_sum_pixel (q18.30), m_pixel_index, m_last_pixel
// cfg_      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_wdata
//
// one transaction per cycle unless the output stalls; results pass stages 1, 2 and the output reg
// the read-add-write loop on the partial-sum memory sets the rate: one read port and one
// write port, with a two-deep forwarding path covering accesses to the same pixel
// reset clears only the position counters and the pipeline; the memory needs no clearing
// since the first mode pass overwrites each entry before any read uses it
// a stalled result holds the whole pipeline; input is taken whenever the output slot frees

module weighted_mode_sum_accumulator_top #(
    parameter int MAX_PIXELS = wmsa_pkg::MAX_PIXELS_DEF,
    parameter int MAX_MODES  = wmsa_pkg::MAX_MODES_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  signed [wmsa_pkg::DATA_W-1:0]  s_mode_pixel,
    input  wire  signed [wmsa_pkg::DATA_W-1:0]  s_weight,

    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [wmsa_pkg::SUM_W-1:0]   m_sum_pixel,
    output logic        [wmsa_pkg::IDX_W-1:0]   m_pixel_index,
    output logic                                m_last_pixel,

    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire         [wmsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire         [wmsa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import wmsa_pkg::*;

    // position widths; count registers carry one more bit so they can hold the limit
    localparam int PIX_W      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int MODE_W     = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int PIX_CNT_W  = PIX_W + 1;
    localparam int MODE_CNT_W = MODE_W + 1;

    localparam int PIX_RST_VAL  = (PIX_RESET > MAX_PIXELS) ? MAX_PIXELS : PIX_RESET;
    localparam int MODE_RST_VAL = (MODE_RESET > MAX_MODES) ? MAX_MODES : MODE_RESET;

    // ------------------------------------------------------------------
    // configuration and position counters
    // ------------------------------------------------------------------
    logic [PIX_CNT_W-1:0]  pix_cnt_reg, pix_cnt_next;
    logic [MODE_CNT_W-1:0] mode_cnt_reg, mode_cnt_next;
    logic [PIX_W-1:0]      pix_reg, pix_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;

    logic        cfg_wr;
    logic        accept;
    logic        advance;
    logic [31:0] pix_req;
    logic [31:0] mode_req;
    logic [31:0] pix_clamped;
    logic [31:0] mode_clamped;
    logic        at_last_pix;
    logic        at_last_mode;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // whole pipeline moves when the output slot is free or being drained
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;

    // zero acts as one, values past the store size or the mode limit saturate
    assign pix_req  = 32'(cfg_wdata[PIX_REQ_W-1:0]);
    assign mode_req = 32'(cfg_wdata[MODE_REQ_W-1:0]);

    always_comb begin
        if (pix_req == 32'd0) begin
            pix_clamped = 32'd1;
        end else if (pix_req > 32'(MAX_PIXELS)) begin
            pix_clamped = 32'(MAX_PIXELS);
        end else begin
            pix_clamped = pix_req;
        end
        if (mode_req == 32'd0) begin
            mode_clamped = 32'd1;
        end else if (mode_req > 32'(MAX_MODES)) begin
            mode_clamped = 32'(MAX_MODES);
        end else begin
            mode_clamped = mode_req;
        end
    end

    assign at_last_pix  = ({1'b0, pix_reg} + PIX_CNT_W'(1)) == pix_cnt_reg;
    assign at_last_mode = ({1'b0, mode_reg} + MODE_CNT_W'(1)) == mode_cnt_reg;

    always_comb begin
        pix_cnt_next  = pix_cnt_reg;
        mode_cnt_next = mode_cnt_reg;
        pix_next      = pix_reg;
        mode_next     = mode_reg;
        if (cfg_wr) begin
            // any register write restarts the image at mode zero
            case (cfg_index)
                REG_PIXELS_IN_USE: begin
                    pix_cnt_next = pix_clamped[PIX_CNT_W-1:0];
                end
                REG_MODES_IN_USE: begin
                    mode_cnt_next = mode_clamped[MODE_CNT_W-1:0];
                end
                default: begin
                    pix_cnt_next = pix_cnt_reg;
                end
            endcase
            pix_next  = '0;
            mode_next = '0;
        end else if (accept) begin
            if (at_last_pix) begin
                pix_next  = '0;
                mode_next = at_last_mode ? '0 : mode_reg + MODE_W'(1);
            end else begin
                pix_next = pix_reg + PIX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_cnt_reg  <= PIX_CNT_W'(PIX_RST_VAL);
            mode_cnt_reg <= MODE_CNT_W'(MODE_RST_VAL);
            pix_reg      <= '0;
            mode_reg     <= '0;
        end else begin
            pix_cnt_reg  <= pix_cnt_next;
            mode_cnt_reg <= mode_cnt_next;
            pix_reg      <= pix_next;
            mode_reg     <= mode_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline: stage 1 holds operands and the memory read,
    // stage 2 holds the product and the forwarded old sum
    // ------------------------------------------------------------------
    logic                     s1_valid_reg;
    logic signed [DATA_W-1:0] s1_pixel_reg;
    logic signed [DATA_W-1:0] s1_weight_reg;
    logic [PIX_W-1:0]         s1_addr_reg;
    logic                     s1_first_reg;
    logic                     s1_emit_reg;
    logic                     s1_last_reg;
    logic                     s1_fwd_hit_reg;
    logic [SUM_W-1:0]         s1_fwd_data_reg;

    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic [SUM_W-1:0]         s2_old_reg;
    logic [PIX_W-1:0]         s2_addr_reg;
    logic                     s2_first_reg;
    logic                     s2_emit_reg;
    logic                     s2_last_reg;

    logic [SUM_W-1:0]         rd_data_reg;
    logic [SUM_W-1:0]         s2_term;
    logic [SUM_W-1:0]         s2_sum;
    logic [SUM_W-1:0]         old_next;
    logic [31:0]              s2_addr_ext;

    logic [SUM_W-1:0] partial_sums_mem [MAX_PIXELS];

    assign s2_term = {{(SUM_W-PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};
    assign s2_sum  = s2_first_reg ? s2_term : s2_old_reg + s2_term;

    // newest write to the same pixel wins: the one leaving stage 2 now,
    // then the one that left while this item's read was issued
    always_comb begin
        if (s2_valid_reg && (s2_addr_reg == s1_addr_reg)) begin
            old_next = s2_sum;
        end else if (s1_fwd_hit_reg) begin
            old_next = s1_fwd_data_reg;
        end else begin
            old_next = rd_data_reg;
        end
    end

    // partial-sum store: one read and one write port
    always_ff @(posedge aclk) begin
        if (advance && s2_valid_reg) begin
            partial_sums_mem[s2_addr_reg] <= s2_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_data_reg <= partial_sums_mem[pix_reg];
        end
    end

    // stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_pixel_reg    <= s_mode_pixel;
            s1_weight_reg   <= s_weight;
            s1_addr_reg     <= pix_reg;
            s1_first_reg    <= (mode_reg == '0);
            s1_emit_reg     <= at_last_mode;
            s1_last_reg     <= at_last_pix;
            s1_fwd_hit_reg  <= s2_valid_reg && (s2_addr_reg == pix_reg);
            s1_fwd_data_reg <= s2_sum;

            s2_prod_reg     <= s1_pixel_reg * s1_weight_reg;
            s2_old_reg      <= old_next;
            s2_addr_reg     <= s1_addr_reg;
            s2_first_reg    <= s1_first_reg;
            s2_emit_reg     <= s1_emit_reg;
            s2_last_reg     <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic                    m_valid_reg;
    logic signed [SUM_W-1:0] m_sum_reg;
    logic [IDX_W-1:0]        m_index_reg;
    logic                    m_last_reg;

    assign s2_addr_ext = 32'(s2_addr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s2_valid_reg && s2_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_sum_reg   <= s2_sum;
            m_index_reg <= s2_addr_ext[IDX_W-1:0];
            m_last_reg  <= s2_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sum_pixel   = m_sum_reg;
    assign m_pixel_index = m_index_reg;
    assign m_last_pixel  = m_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pix_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, pix_reg} < pix_cnt_reg)
        else $error("pixel position past pixel count");

    a_mode_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, mode_reg} < mode_cnt_reg)
        else $error("mode position past mode count");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted transaction missing from stage 1");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s2_valid_reg && s2_emit_reg))
        else $error("result without a last-pass item behind it");

endmodule

`default_nettype wire
